// ===== hw/rtl/fqdt_pkg.sv =====
// Shared types, constants and control-store contents for the fixed-point
// to decimal text unit. No dependencies.
package fqdt_pkg;

	localparam int QBITS = 16;
	localparam int WORD_W = 32;
	localparam int VAL_W = 17;
	localparam int STEP_W = 3;
	localparam logic [2:0] MAX_DIGITS = 3'd5;
	localparam logic [15:0] ROUND_LIMIT = 16'd32767;

	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_MINUS = 7'h2d;
	localparam logic [6:0] CHAR_POINT = 7'h2e;

	localparam logic REG_FRACTION_DIGITS = 1'b0;
	localparam logic REG_INPUT_FRACTION_BITS = 1'b1;

	localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;

	typedef enum logic [2:0] {
		UOP_WAIT = 3'd0,
		UOP_MAG = 3'd1,
		UOP_MUL = 3'd2,
		UOP_ROUND = 3'd3,
		UOP_SIGN = 3'd4,
		UOP_INT_DIGIT = 3'd5,
		UOP_DOT = 3'd6,
		UOP_FRAC_DIGIT = 3'd7
	} uop_t;

	typedef enum logic [1:0] {
		COND_GO = 2'd0,
		COND_IN = 2'd1,
		COND_LOOP = 2'd2,
		COND_FRAC = 2'd3
	} cond_t;

	typedef struct packed {
		uop_t uop;
		cond_t cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic in_fire;
		logic pos_zero;
		logic has_frac;
		logic stall;
	} status_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			3'd0: w = '{UOP_WAIT, COND_IN, 3'd1};
			3'd1: w = '{UOP_MAG, COND_GO, 3'd2};
			3'd2: w = '{UOP_MUL, COND_GO, 3'd3};
			3'd3: w = '{UOP_ROUND, COND_GO, 3'd4};
			3'd4: w = '{UOP_SIGN, COND_GO, 3'd5};
			3'd5: w = '{UOP_INT_DIGIT, COND_LOOP, 3'd6};
			3'd6: w = '{UOP_DOT, COND_FRAC, 3'd7};
			3'd7: w = '{UOP_FRAC_DIGIT, COND_LOOP, STEP_IDLE};
			default: w = '{UOP_WAIT, COND_IN, 3'd1};
		endcase
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] pow10(input logic [2:0] idx);
		logic [VAL_W-1:0] p;
		case (idx)
			3'd0: p = 17'd1;
			3'd1: p = 17'd10;
			3'd2: p = 17'd100;
			3'd3: p = 17'd1000;
			3'd4: p = 17'd10000;
			3'd5: p = 17'd100000;
			default: p = 17'd100000;
		endcase
		return p;
	endfunction

endpackage

// ===== hw/rtl/fqdt_useq.sv =====
// Micro-sequencer: step counter and control store with conditional jumps.
// Depends on fqdt_pkg.
module fqdt_useq (
	input logic clk,
	input logic arst_n,
	input fqdt_pkg::status_t status,
	output fqdt_pkg::uop_t uop
);
	import fqdt_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	ucode_t word;

	assign word = ucode_rom(step_q);
	assign uop = word.uop;

	always_comb begin
		step_nxt = step_q;
		if (!status.stall) begin
			case (word.cond)
				COND_GO: step_nxt = word.target;
				COND_IN: if (status.in_fire) step_nxt = word.target;
				COND_LOOP: if (status.pos_zero) step_nxt = word.target;
				COND_FRAC: step_nxt = status.has_frac ? word.target : STEP_IDLE;
				default: step_nxt = STEP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// ===== hw/rtl/fqdt_datapath.sv =====
// Datapath: shift and magnitude, fraction scaling and rounding, one decimal
// digit per step, and the output character register. Depends on fqdt_pkg.
module fqdt_datapath (
	input logic clk,
	input logic arst_n,
	input fqdt_pkg::uop_t uop,
	output fqdt_pkg::status_t status,
	input logic [2:0] cfg_digits,
	input logic [4:0] cfg_frac_bits,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] fixed_value,
	output logic out_valid,
	input logic out_ready,
	output logic [6:0] text_char,
	output logic last_char
);
	import fqdt_pkg::*;

	logic [WORD_W-1:0] raw_q;
	logic [3:0] sh_q;
	logic [2:0] digits_q;
	logic [WORD_W-1:0] mag_q;
	logic [32:0] prod_q;
	logic [VAL_W-1:0] frac_q;
	logic [VAL_W-1:0] val_q;
	logic [2:0] pos_q;
	logic lead_q;
	logic out_valid_q;
	logic [6:0] text_char_q;
	logic last_char_q;

	logic in_fire;
	logic neg;
	logic [WORD_W-1:0] shifted;
	logic [VAL_W-1:0] frac_rnd;
	logic [VAL_W-1:0] whole_val;
	logic [VAL_W-1:0] scale;
	logic [VAL_W-1:0] place;
	logic [VAL_W-1:0] thresh;
	logic [VAL_W-1:0] sub;
	logic [3:0] dig;
	logic pos_zero;
	logic emit;
	logic emit_last;
	logic [6:0] emit_char;
	logic out_free;
	logic stall;
	logic advance;

	assign in_ready = (uop == UOP_WAIT);
	assign in_fire = in_valid && in_ready;
	assign neg = raw_q[WORD_W-1];
	assign shifted = WORD_W'($signed(raw_q) >>> sh_q);
	assign scale = pow10(digits_q);
	assign pos_zero = (pos_q == 3'd0);

	always_comb begin
		frac_rnd = prod_q[32:16] + VAL_W'(prod_q[15:0] >= ROUND_LIMIT);
		whole_val = {1'b0, mag_q[31:16]};
		if (frac_rnd >= scale) begin
			whole_val = whole_val + 17'd1;
			frac_rnd = '0;
		end
	end

	always_comb begin
		place = pow10(pos_q);
		dig = 4'd0;
		sub = '0;
		thresh = '0;
		for (int k = 1; k <= 9; k++) begin
			thresh = VAL_W'(place * VAL_W'(k));
			if (val_q >= thresh) begin
				dig = 4'(k);
				sub = thresh;
			end
		end
	end

	always_comb begin
		emit = 1'b0;
		emit_last = 1'b0;
		emit_char = CHAR_ZERO;
		case (uop)
			UOP_SIGN: begin
				emit = neg;
				emit_char = CHAR_MINUS;
			end
			UOP_INT_DIGIT: begin
				emit = (dig != 4'd0) || lead_q || pos_zero;
				emit_char = CHAR_ZERO + 7'(dig);
				emit_last = pos_zero && (digits_q == 3'd0);
			end
			UOP_DOT: begin
				emit = (digits_q != 3'd0);
				emit_char = CHAR_POINT;
			end
			UOP_FRAC_DIGIT: begin
				emit = 1'b1;
				emit_char = CHAR_ZERO + 7'(dig);
				emit_last = pos_zero;
			end
			default: emit = 1'b0;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign stall = emit && !out_free;
	assign advance = !stall;

	assign status = '{in_fire: in_fire, pos_zero: pos_zero,
		has_frac: (digits_q != 3'd0), stall: stall};

	always_ff @(posedge clk) begin
		if (advance) begin
			case (uop)
				UOP_WAIT: begin
					if (in_fire) begin
						raw_q <= fixed_value;
						sh_q <= cfg_frac_bits[4] ? cfg_frac_bits[3:0] : 4'd0;
						digits_q <= (cfg_digits > MAX_DIGITS) ? MAX_DIGITS : cfg_digits;
					end
				end
				UOP_MAG: mag_q <= neg ? (WORD_W'(0) - shifted) : shifted;
				UOP_MUL: prod_q <= 33'(mag_q[15:0]) * 33'(scale);
				UOP_ROUND: begin
					val_q <= whole_val;
					frac_q <= frac_rnd;
					pos_q <= 3'd4;
					lead_q <= 1'b0;
				end
				UOP_INT_DIGIT, UOP_FRAC_DIGIT: begin
					if (uop == UOP_INT_DIGIT && pos_zero) begin
						val_q <= frac_q;
						pos_q <= digits_q - 3'd1;
					end else begin
						val_q <= val_q - sub;
						pos_q <= pos_q - 3'd1;
					end
					if (dig != 4'd0) lead_q <= 1'b1;
				end
				default: lead_q <= lead_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			text_char_q <= emit_char;
			last_char_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

endmodule

// ===== hw/rtl/fixed_q16_to_decimal_text_unit.sv =====
// Top level: configuration registers, micro-sequencer and datapath.
// Depends on fqdt_pkg, fqdt_useq, fqdt_datapath.
//
//   channel | signals                           | beat
//   in      | in_valid, in_ready, fixed_value   | one fixed-point word
//   out     | out_valid, out_ready, text_char,  | one ASCII character,
//           | last_char                         | last_char on the final one
//   cfg     | cfg_we, cfg_index, cfg_data       | one register write
//
// One word at a time: 1 accept step, 3 prep steps (shift/negate, multiply,
// round), sign step, 5 integer digit steps, point step and one step per
// fraction digit.
// The sequencer holds a character-emitting step while the output register is full and not taken.
// Reset clears the step counter, the output valid and the registers to
// fraction_digits = 2, input_fraction_bits = 16.
module fixed_q16_to_decimal_text_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] fixed_value,
	output logic out_valid,
	input logic out_ready,
	output logic [6:0] text_char,
	output logic last_char,
	input logic cfg_we,
	input logic cfg_index,
	input logic [4:0] cfg_data
);
	import fqdt_pkg::*;

	logic [2:0] fraction_digits_q;
	logic [4:0] input_fraction_bits_q;
	uop_t uop;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_digits_q <= 3'd2;
			input_fraction_bits_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRACTION_DIGITS: fraction_digits_q <= cfg_data[2:0];
				REG_INPUT_FRACTION_BITS: input_fraction_bits_q <= cfg_data;
				default: fraction_digits_q <= fraction_digits_q;
			endcase
		end
	end

	fqdt_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.uop(uop)
	);

	fqdt_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.uop(uop),
		.status(status),
		.cfg_digits(fraction_digits_q),
		.cfg_frac_bits(input_fraction_bits_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.fixed_value(fixed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_char(text_char),
		.last_char(last_char)
	);

endmodule

// ===== tb/sv/fixed_q16_to_decimal_text_unit_test.sv =====
// Self-checking bench for the fixed-point to decimal text unit: directed table,
// then random words under four idle/stall mixes and a long output hold-off.
// Depends on fqdt_pkg and fixed_q16_to_decimal_text_unit.
module fixed_q16_to_decimal_text_unit_test;
	import fqdt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int WORDS_PER_PHASE = 19;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic [6:0] ch;
		logic last;
	} text_beat_t;

	typedef struct {
		int fd;
		int ifb;
		logic [31:0] word;
		string text;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] fixed_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [6:0] text_char;
	logic last_char;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_FRACTION_DIGITS;
	logic [4:0] cfg_data = '0;

	logic [2:0] cur_fd = 3'd2;
	logic [4:0] cur_ifb = 5'd16;
	text_beat_t text_due[$];
	dir_row_t dir_rows[25];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int errors = 0;
	int cycles = 0;
	int words_sent = 0;
	int chars_checked = 0;
	int settings = 0;

	fixed_q16_to_decimal_text_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.fixed_value(fixed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_char(text_char),
		.last_char(last_char),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic string format_decimal(input logic [31:0] word);
		logic [4:0] sh;
		logic [31:0] shifted;
		logic [31:0] mag;
		logic [47:0] prod;
		int unsigned nd;
		int unsigned scale;
		int unsigned ipart;
		int unsigned fpart;
		string s;
		string f;
		sh = (cur_ifb >= 5'd16) ? cur_ifb - 5'd16 : 5'd0;
		shifted = $signed(word) >>> sh;
		mag = word[31] ? -shifted : shifted;
		nd = (cur_fd > 3'd5) ? 5 : cur_fd;
		scale = 1;
		for (int i = 0; i < nd; i++)
			scale *= 10;
		prod = 48'(mag[15:0]) * 48'(scale);
		fpart = prod[47:16] + ((prod[15:0] >= 16'd32767) ? 1 : 0);
		ipart = 32'(mag[31:16]);
		if (fpart >= scale) begin
			ipart++;
			fpart = 0;
		end
		s = "";
		if (word[31])
			s = "-";
		s = {s, $sformatf("%0d", ipart)};
		if (nd != 0) begin
			f = $sformatf("%0d", fpart);
			while (f.len() < nd)
				f = {"0", f};
			s = {s, ".", f};
		end
		return s;
	endfunction

	function automatic void push_text(input string s);
		text_beat_t b;
		for (int i = 0; i < s.len(); i++) begin
			b.ch = 7'(s[i]);
			b.last = (i == s.len() - 1);
			text_due.push_back(b);
		end
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int sel;
		sel = $urandom_range(5);
		case (sel)
			0, 1: w = $urandom;
			2: w = $urandom_range(32'h3FFFF);
			3: w = {16'($urandom), 8'hFF, 8'($urandom)};
			4: w = {16'($urandom), 16'h0000};
			default: begin
				case ($urandom_range(3))
					0: w = 32'h7FFFFFFF;
					1: w = 32'h80000000;
					2: w = 32'h00000000;
					default: w = 32'hFFFFFFFF;
				endcase
			end
		endcase
		if (sel >= 2 && sel <= 4 && $urandom_range(1))
			w = -w;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 20)
			$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
	endtask

	// Entered and left just after a falling edge; valid stays up between words unless an idle gap is drawn.
	task automatic put_word(input logic [31:0] word, input string text);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		fixed_value <= word;
		do
			@(posedge clk);
		while (!in_ready);
		if (text.len() != 0)
			push_text(text);
		else
			push_text(format_decimal(word));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (text_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_format(input int fd, input int ifb);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_FRACTION_DIGITS;
		cfg_data <= {2'($urandom), 3'(fd)};
		@(negedge clk);
		cfg_index <= REG_INPUT_FRACTION_BITS;
		cfg_data <= 5'(ifb);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_fd = 3'(fd);
		cur_ifb = 5'(ifb);
		settings++;
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (text_due.size() == 0) begin
				report_mismatch("character with nothing due", text_char, 0);
			end else begin
				want = text_due.pop_front();
				if (text_char !== want.ch)
					report_mismatch("text_char", text_char, want.ch);
				if (last_char !== want.last)
					report_mismatch("last_char", last_char, want.last);
				chars_checked++;
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout with %0d characters still due", text_due.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		int fd;
		int ifb;
		int idle_tab[4];
		int stall_tab[4];
		idle_tab = '{0, 56, 0, 20};
		stall_tab = '{0, 0, 56, 20};
		dir_rows = '{
			'{2, 16, 32'h00000000, "0.00"},
			'{2, 16, 32'h00010000, "1.00"},
			'{2, 16, 32'hFFFF0000, "-1.00"},
			'{2, 16, 32'h7FFFFFFF, "32768.00"},
			'{2, 16, 32'h80000000, "-32768.00"},
			'{2, 16, 32'hFFFFFFFF, "-0.00"},
			'{2, 16, 32'h00008000, "0.50"},
			'{2, 16, 32'h0000FFFF, "1.00"},
			'{2, 16, 32'h3039AB85, ""},
			'{2, 16, 32'h0000147A, ""},
			'{2, 16, 32'hCFC6547B, ""},
			'{0, 16, 32'h00018000, "2"},
			'{0, 16, 32'h00017FFE, "1"},
			'{0, 16, 32'h80000000, "-32768"},
			'{5, 16, 32'h7FFFFFFF, "32767.99998"},
			'{5, 16, 32'h80000000, "-32768.00000"},
			'{5, 16, 32'h0000000F, ""},
			'{7, 16, 32'h7FFFFFFF, "32767.99998"},
			'{6, 16, 32'hFFFFFFFF, ""},
			'{2, 31, 32'h80000000, "-1.00"},
			'{2, 31, 32'h7FFFFFFF, "1.00"},
			'{2, 0, 32'h00010000, "1.00"},
			'{3, 20, 32'h00100000, "1.000"},
			'{1, 15, 32'h00028000, ""},
			'{4, 24, 32'hFFFFFFFF, ""}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].fd != cur_fd || dir_rows[i].ifb != cur_ifb)
				set_format(dir_rows[i].fd, dir_rows[i].ifb);
			put_word(dir_rows[i].word, dir_rows[i].text);
		end

		for (int p = 0; p < 4; p++) begin
			fd = $urandom_range(7);
			ifb = $urandom_range(1) ? 16 : $urandom_range(31);
			set_format(fd, ifb);
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			// long output hold-off while words keep coming
			if (p == 0)
				hold_cycles = 150;
			repeat (WORDS_PER_PHASE) put_word(random_word(), "");
		end

		drain();
		$display("%0d words sent, %0d characters compared", words_sent, chars_checked);
		$display("%0d register settings, four idle/stall mixes, one long hold-off", settings);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
